>>> hw/rtl/mes_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape shade package
// Shared payload types, controller/datapath command and status, FSM states
// and default constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mes_pkg;

	// default configuration of the iteration
	localparam int unsigned MAX_ITER_DEF  = 100;
	localparam int unsigned FRAC_BITS_DEF = 28;

	// fixed field widths
	localparam int unsigned COORD_W = 32;
	localparam int unsigned DIV_W   = 7;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned SHADE_W = 9;

	// shade scale and convergence denominator (threshold is 2^(2F) / 1e8, rounded up)
	localparam int unsigned SHADE_FULL = 255;
	localparam longint unsigned CONV_DEN = 64'd100000000;

	// shade code for a point that hit the iteration limit
	localparam logic signed [SHADE_W-1:0] SHADE_NONE = -9'sd1;

	// input point
	typedef struct packed {
		logic signed [COORD_W-1:0] c_re;
		logic signed [COORD_W-1:0] c_im;
		logic signed [COORD_W-1:0] start_re;
		logic signed [COORD_W-1:0] start_im;
		logic                      clear_peak;
	} point_t;

	// result item
	typedef struct packed {
		logic signed [SHADE_W-1:0] shade;
		logic [CNT_W-1:0]          iterations;
		logic [CNT_W-1:0]          peak_iterations;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // take a new point
		logic step;       // commit z_new and count the iteration
		logic div_start;  // start the shade division
		logic out_load;   // capture the result and update the peak
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stop;       // escaped or at the iteration limit
		logic conv;       // step small enough: converged
		logic div_done;   // shade quotient ready
	} dp_sts_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DIFF,
		ST_CONV,
		ST_DIV,
		ST_WAIT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mes_if.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape shade channels
// Valid/ready channels for points, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

// point channel
interface mes_point_if;
	logic            valid;
	logic            ready;
	mes_pkg::point_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface mes_result_if;
	logic             valid;
	logic             ready;
	mes_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// configuration write channel (shade divisor)
interface mes_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mes_pkg::DIV_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mes_div.sv
// ----------------------------------------------------------------------------
// Shade divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_div #(
	parameter int unsigned NUM_W = 15,
	parameter int unsigned DEN_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	localparam int unsigned CNT_BITS = $clog2(NUM_W + 1);

	logic [DEN_W-1:0]    rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DEN_W:0]      trial;
	logic                fits;

	// shift in the next numerator bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = (trial >= {1'b0, den});
	end

	// control: bit counter and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_BITS'(1));
		end
	end

	// remainder and quotient (numerator shifts out as quotient shifts in)
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, den});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/mes_datapath.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape shade datapath
// z registers, squaring stage, update and saturation, convergence test,
// peak count, divisor register, shade division and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_datapath #(
	parameter int unsigned MAX_ITER  = mes_pkg::MAX_ITER_DEF,
	parameter int unsigned FRAC_BITS = mes_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mes_pkg::dp_cmd_t cmd,
	output mes_pkg::dp_sts_t      sts,
	input  wire mes_pkg::point_t  pt_data,
	input  wire logic             cfg_we,
	input  wire logic [mes_pkg::DIV_W-1:0] cfg_data,
	output mes_pkg::result_t      res_data
);
	import mes_pkg::*;

	localparam int unsigned ITER_W = $clog2(MAX_ITER + 1);
	localparam int unsigned NUM_W  = ITER_W + 8;
	localparam int unsigned DEN_W  = (ITER_W > DIV_W) ? ITER_W : DIV_W;
	localparam int unsigned SQ_W   = 2 * FRAC_BITS + 1;

	localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);
	localparam logic [63:0] CONV_THR  =
		((64'd1 << (2 * FRAC_BITS)) + CONV_DEN - 64'd1) / CONV_DEN;
	localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
	localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [64:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[COORD_W-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	// iteration state
	logic signed [COORD_W-1:0] x_q, y_q, cre_q, cim_q;
	logic [ITER_W-1:0]         it_q;
	logic [ITER_W-1:0]         peak_q;
	logic [DIV_W-1:0]          div_q;

	// squaring stage
	logic signed [63:0]        xx_q, yy_q, xy_q;

	// update stage
	logic signed [COORD_W-1:0] nx_q, ny_q;
	logic signed [63:0]        re_d, im_d, re_sh, im_sh;
	logic signed [64:0]        re_w, im_w, cre_w, cim_w;
	logic [63:0]               mag_c;

	// step difference stage
	logic signed [COORD_W:0]   nxw, nyw, xw, yw, ex, ey;
	logic [COORD_W:0]          ax, ay;
	logic                      bigx_q, bigy_q;
	logic [FRAC_BITS-1:0]      lowx_q, lowy_q;
	logic [SQ_W-1:0]           sq_c;

	// shade division
	logic [NUM_W-1:0]          num_c;
	logic [DEN_W-1:0]          den_c;
	logic [NUM_W-1:0]          quo;
	logic                      div_done;
	logic [ITER_W-1:0]         peak_nxt;
	logic                      at_limit;
	logic [7:0]                shade8;

	// divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
		end else if (cfg_we) begin
			div_q <= cfg_data;
		end
	end

	// z, c and count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= pt_data.start_re;
			y_q   <= pt_data.start_im;
			cre_q <= pt_data.c_re;
			cim_q <= pt_data.c_im;
			it_q  <= '0;
		end else if (cmd.step) begin
			x_q  <= nx_q;
			y_q  <= ny_q;
			it_q <= it_q + 1'b1;
		end
	end

	// exact products of the current z
	always_ff @(posedge clk) begin
		xx_q <= x_q * x_q;
		yy_q <= y_q * y_q;
		xy_q <= x_q * y_q;
	end

	// z_new = z^2 + c with floor shift and saturation; escape test
	always_comb begin
		re_d  = xx_q - yy_q;
		im_d  = xy_q <<< 1;
		re_sh = re_d >>> FRAC_BITS;
		im_sh = im_d >>> FRAC_BITS;
		re_w  = re_sh;
		im_w  = im_sh;
		cre_w = cre_q;
		cim_w = cim_q;
		mag_c = $unsigned(xx_q) + $unsigned(yy_q);
	end

	always_ff @(posedge clk) begin
		nx_q <= sat32(re_w + cre_w);
		ny_q <= sat32(im_w + cim_w);
	end

	assign at_limit = (it_q >= ITER_W'(MAX_ITER));
	assign sts.stop = (mag_c > ESC_LIMIT) || at_limit;

	// magnitude of the step per component
	always_comb begin
		nxw = nx_q;
		nyw = ny_q;
		xw  = x_q;
		yw  = y_q;
		ex  = nxw - xw;
		ey  = nyw - yw;
		ax  = ex[COORD_W] ? $unsigned(-ex) : $unsigned(ex);
		ay  = ey[COORD_W] ? $unsigned(-ey) : $unsigned(ey);
	end

	always_ff @(posedge clk) begin
		bigx_q <= |ax[COORD_W:FRAC_BITS];
		bigy_q <= |ay[COORD_W:FRAC_BITS];
		lowx_q <= ax[FRAC_BITS-1:0];
		lowy_q <= ay[FRAC_BITS-1:0];
	end

	// squared step against the convergence threshold
	always_comb begin
		sq_c = SQ_W'(lowx_q * lowx_q) + SQ_W'(lowy_q * lowy_q);
	end

	assign sts.conv = !bigx_q && !bigy_q && (64'(sq_c) < CONV_THR);

	// count * 255 / divisor
	assign num_c = {it_q, 8'h00} - NUM_W'(it_q);
	assign den_c = (div_q == '0) ? DEN_W'(MAX_ITER) : DEN_W'(div_q);

	mes_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_c),
		.den    (den_c),
		.done   (div_done),
		.quo    (quo)
	);

	assign sts.div_done = div_done;

	// peak of the counts that stayed below the limit
	assign peak_nxt = (!at_limit && (it_q > peak_q)) ? it_q : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cmd.load && pt_data.clear_peak) begin
			peak_q <= '0;
		end else if (cmd.out_load) begin
			peak_q <= peak_nxt;
		end
	end

	// saturated shade
	assign shade8 = (|quo[NUM_W-1:8]) ? 8'(SHADE_FULL) : quo[7:0];

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_data.shade           <= at_limit ? SHADE_NONE : $signed({1'b0, shade8});
			res_data.iterations      <= CNT_W'(it_q);
			res_data.peak_iterations <= CNT_W'(peak_nxt);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/mes_ctrl.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape shade controller
// Sequences one point through the iteration loop, the shade division and
// the result register; owns the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mes_pkg::dp_cmd_t      cmd,
	input  wire mes_pkg::dp_sts_t sts
);
	import mes_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// result slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_UPD;
			ST_UPD:  state_nxt = sts.stop ? ST_DIV : ST_DIFF;
			ST_DIFF: state_nxt = ST_CONV;
			ST_CONV: state_nxt = sts.conv ? ST_DIV : ST_MUL;
			ST_DIV:  state_nxt = ST_WAIT;
			ST_WAIT: if (sts.div_done) state_nxt = ST_OUT;
			ST_OUT:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: cmd.step      = !sts.conv;
			ST_DIV:  cmd.div_start = 1'b1;
			ST_OUT:  cmd.out_load  = out_free;
			default: cmd = '0;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/mandelbrot_escape_shade.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape shade
// Escape-time iteration of z = z*z + c in signed fixed point with a scaled
// shade, the exit count and a running peak count per point.
// ----------------------------------------------------------------------------
// One point at a time. Each iteration steps through square, update and
// escape test, step difference and convergence test; the last one ends
// after the escape test or after the convergence test. Then the shade
// divider runs one quotient bit per cycle over clog2(MAX_ITER+1)+8 bits,
// with hand-off steps around the loop and the divider (accept, divider
// start, done seen, result load); the result may then wait to be taken.
// The loop of the shared squaring datapath sets the time per point.
// A new point is accepted as soon as the previous one sits in the result
// register, even while that result waits to be taken. The shade divisor is
// written on its own channel, always ready; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_shade #(
	parameter int unsigned MAX_ITER  = mes_pkg::MAX_ITER_DEF,
	parameter int unsigned FRAC_BITS = mes_pkg::FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mes_point_if.sink    point,
	mes_result_if.source result,
	mes_cfg_if.sink      cfg
);
	import mes_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// configuration writes always transfer
	assign cfg.ready = 1'b1;

	mes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mes_datapath #(
		.MAX_ITER  (MAX_ITER),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.pt_data  (point.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.res_data (result.data)
	);

endmodule

`default_nettype wire
